// ===== rtl/lbpc_pkg.sv =====
// shared types, codes and defaults for the led blink pattern controller
package lbpc_pkg;

  localparam int LedNumDef = 3;
  localparam int TickMsDef = 10;

  localparam int LedW       = 3;
  localparam int HalfW      = 16;
  localparam int StateAgeW  = 17;
  localparam int PatAgeW    = 32;
  localparam int CfgIdxW    = 2;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  localparam logic [1:0] PAT_OFF  = 2'd0;
  localparam logic [1:0] PAT_ON   = 2'd1;
  localparam logic [1:0] PAT_SLOW = 2'd2;
  localparam logic [1:0] PAT_FAST = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_IDX = 2'd1;
  localparam logic [1:0] ST_BAD_PAT = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_MASK = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SLOW = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FAST = 2'd2;

  localparam logic [HalfW-1:0] SLOW_RST = 16'd500;
  localparam logic [HalfW-1:0] FAST_RST = 16'd100;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  led_index;
    logic [2:0]  pattern;
    logic [31:0] life_ms;
  } lbpc_in_t;

  typedef struct packed {
    logic [2:0] led_lit;
    logic [1:0] status;
  } lbpc_out_t;

  typedef struct packed {
    logic        tick;
    logic        run;
    logic        clr;
    logic [1:0]  pattern;
    logic [31:0] timeout;
  } lbpc_cmd_t;

endpackage

// ===== rtl/lbpc_led_unit.sv =====
// per-led pattern, timeout and level state with its tick, run and clear update
module lbpc_led_unit #(
  parameter int TICK_MS = lbpc_pkg::TickMsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  lbpc_pkg::lbpc_cmd_t        cmd_i,
  input  logic [lbpc_pkg::HalfW-1:0] slow_half_i,
  input  logic [lbpc_pkg::HalfW-1:0] fast_half_i,
  output logic                       lit_d_o
);
  import lbpc_pkg::*;

  localparam logic [PatAgeW:0]   TickPa = (PatAgeW+1)'(TICK_MS);
  localparam logic [StateAgeW:0] TickSa = (StateAgeW+1)'(TICK_MS);
  localparam logic [StateAgeW-1:0] SaMax = {StateAgeW{1'b1}};

  logic [1:0]           pat_q, pat_d;
  logic                 lit_q, lit_d;
  logic [StateAgeW-1:0] sa_q, sa_d;
  logic [PatAgeW-1:0]   pa_q, pa_d;
  logic [31:0]          tmo_q, tmo_d;

  logic [PatAgeW:0]     pa_sum;
  logic [PatAgeW-1:0]   pa_sat;
  logic [StateAgeW:0]   sa_sum;
  logic [StateAgeW-1:0] sa_sat;
  logic [1:0]           pat_eff;
  logic [HalfW-1:0]     half;
  logic                 expired;

  always_comb begin
    pa_sum  = {1'b0, pa_q} + TickPa;
    pa_sat  = pa_sum[PatAgeW] ? {PatAgeW{1'b1}} : pa_sum[PatAgeW-1:0];
    sa_sum  = {1'b0, sa_q} + TickSa;
    sa_sat  = sa_sum[StateAgeW] ? SaMax : sa_sum[StateAgeW-1:0];
    expired = (tmo_q != 32'd0) && (pa_sat >= tmo_q);
    pat_eff = expired ? PAT_OFF : pat_q;
    half    = (pat_eff == PAT_SLOW) ? slow_half_i : fast_half_i;

    pat_d = pat_q;
    lit_d = lit_q;
    sa_d  = sa_q;
    pa_d  = pa_q;
    tmo_d = tmo_q;

    if (en_i && cmd_i.tick) begin
      pat_d = pat_eff;
      pa_d  = expired ? '0 : pa_sat;
      if (!((pat_eff == PAT_OFF && !lit_q) || (pat_eff == PAT_ON && lit_q))) begin
        case (pat_eff)
          PAT_OFF: begin
            lit_d = 1'b0;
            sa_d  = '0;
          end
          PAT_ON: begin
            lit_d = 1'b1;
            sa_d  = '0;
          end
          default: begin
            if (sa_sat >= StateAgeW'(half)) begin
              lit_d = ~lit_q;
              sa_d  = '0;
            end else begin
              sa_d = sa_sat;
            end
          end
        endcase
      end
    end else if (en_i && cmd_i.run) begin
      pat_d = cmd_i.pattern;
      tmo_d = cmd_i.timeout;
      pa_d  = '0;
    end else if (en_i && cmd_i.clr) begin
      pat_d = PAT_OFF;
      pa_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= PAT_OFF;
      lit_q <= 1'b0;
      sa_q  <= '0;
      pa_q  <= '0;
      tmo_q <= '0;
    end else begin
      pat_q <= pat_d;
      lit_q <= lit_d;
      sa_q  <= sa_d;
      pa_q  <= pa_d;
      tmo_q <= tmo_d;
    end
  end

  assign lit_d_o = lit_d;

endmodule

// ===== rtl/led_blink_pattern_controller.sv =====
// top level of the led blink pattern controller: request register, led units, result register
//
// usage:
//   requests enter on in_valid_i/in_ready_o with an lbpc_in_t payload: a tick,
//   a run command (pattern and timeout for one led) or a reset of one led's
//   pattern. every request gives exactly one result on out_valid_o/out_ready_i
//   carrying the led vector after the request and a status code.
//   registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i: 0 present
//   mask, 1 slow half period, 2 fast half period; other indexes are ignored.
//   flow: a request taken is held in the request register, evaluated against
//   the led state when the result register can take its result, and the
//   result is then held in the result register until out_ready_i.
//   throughput: one request per cycle while out_ready_i is high; every led unit
//   updates in parallel in the single evaluation stage between the two registers.
//   reset: all leds off, patterns off, ages and timeouts cleared, mask zero,
//   half periods 500 and 100 ms; no request or result is pending.
//   stall: while a result waits, one more request is still taken into the
//   request register; after that in_ready_o drops until out_ready_i rises.
module led_blink_pattern_controller #(
  parameter int LED_NUM = lbpc_pkg::LedNumDef,
  parameter int TICK_MS = lbpc_pkg::TickMsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lbpc_pkg::lbpc_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lbpc_pkg::lbpc_out_t          out_data_o,
  input  logic                         cfg_we_i,
  input  logic [lbpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lbpc_pkg::HalfW-1:0]   cfg_wdata_i
);
  import lbpc_pkg::*;

  logic [LedW-1:0]  mask_q;
  logic [HalfW-1:0] slow_q;
  logic [HalfW-1:0] fast_q;

  lbpc_in_t  req_q;
  logic      req_valid_q;
  lbpc_out_t res_q, res_d;
  logic      res_valid_q;
  logic      fire;
  logic      idx_bad;
  logic      pat_bad;
  logic [LedW-1:0] lit_d;

  assign fire       = req_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || fire;
  assign idx_bad    = 32'(req_q.led_index) >= LED_NUM;
  assign pat_bad    = req_q.pattern[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      slow_q <= SLOW_RST;
      fast_q <= FAST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MASK: mask_q <= cfg_wdata_i[LedW-1:0];
        REG_SLOW: slow_q <= cfg_wdata_i;
        REG_FAST: fast_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_data_i;
    end
  end

  for (genvar i = 0; i < LedW; i++) begin : g_led
    if (i < LED_NUM) begin : g_on
      lbpc_cmd_t cmd;
      always_comb begin
        cmd.tick    = (req_q.op == OP_TICK) && mask_q[i];
        cmd.run     = (req_q.op == OP_RUN) && (req_q.led_index == LedW'(i)) && !pat_bad;
        cmd.clr     = (req_q.op == OP_RESET) && (req_q.led_index == LedW'(i));
        cmd.pattern = req_q.pattern[1:0];
        cmd.timeout = req_q.life_ms;
      end
      lbpc_led_unit #(
        .TICK_MS(TICK_MS)
      ) u_led (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .en_i       (fire),
        .cmd_i      (cmd),
        .slow_half_i(slow_q),
        .fast_half_i(fast_q),
        .lit_d_o    (lit_d[i])
      );
    end else begin : g_off
      assign lit_d[i] = 1'b0;
    end
  end

  always_comb begin
    res_d.led_lit = lit_d;
    res_d.status  = ST_OK;
    if (req_q.op == OP_RUN || req_q.op == OP_RESET) begin
      if (idx_bad) begin
        res_d.status = ST_BAD_IDX;
      end else if (req_q.op == OP_RUN && pat_bad) begin
        res_d.status = ST_BAD_PAT;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

// ===== test/led_pattern_checker.sv =====
// checker for the led blink pattern controller: mirrors the led state and compares every result
module led_pattern_checker
  import lbpc_pkg::*;
#(
  parameter int LedNum = LedNumDef,
  parameter int TickMs = TickMsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  lbpc_in_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  lbpc_out_t          out_data_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [HalfW-1:0]   cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  logic [LedW-1:0]      mask_q;
  logic [HalfW-1:0]     slow_q;
  logic [HalfW-1:0]     fast_q;
  logic [1:0]           pat_q       [LedNum];
  logic [LedNum-1:0]    lit_q;
  logic [StateAgeW-1:0] level_age_q [LedNum];
  logic [PatAgeW-1:0]   pat_age_q   [LedNum];
  logic [31:0]          timeout_q   [LedNum];
  lbpc_out_t            awaited_q   [$];

  task automatic tick_led(input int i);
    logic [PatAgeW:0] pat_sum;
    logic [31:0]      level_sum;
    logic [HalfW-1:0] half;
    pat_sum = pat_age_q[i] + TickMs;
    pat_age_q[i] = pat_sum[PatAgeW] ? '1 : pat_sum[PatAgeW-1:0];
    if (timeout_q[i] != '0 && pat_age_q[i] >= timeout_q[i]) begin
      pat_q[i]     = PAT_OFF;
      pat_age_q[i] = '0;
    end
    // settled leds keep their level age
    if ((pat_q[i] == PAT_OFF && !lit_q[i]) || (pat_q[i] == PAT_ON && lit_q[i])) return;
    level_sum = level_age_q[i] + TickMs;
    level_age_q[i] = (level_sum > 2**StateAgeW - 1) ? '1 : level_sum[StateAgeW-1:0];
    case (pat_q[i])
      PAT_OFF: begin
        lit_q[i]       = 1'b0;
        level_age_q[i] = '0;
      end
      PAT_ON: begin
        lit_q[i]       = 1'b1;
        level_age_q[i] = '0;
      end
      default: begin
        half = (pat_q[i] == PAT_SLOW) ? slow_q : fast_q;
        if (level_age_q[i] >= half) begin
          lit_q[i]       = !lit_q[i];
          level_age_q[i] = '0;
        end
      end
    endcase
  endtask

  task automatic step_leds(input lbpc_in_t req, output lbpc_out_t res);
    res.status = ST_OK;
    case (req.op)
      OP_TICK: begin
        for (int i = 0; i < LedNum; i++) if (mask_q[i]) tick_led(i);
      end
      OP_RUN, OP_RESET: begin
        if (req.led_index >= LedNum) begin
          res.status = ST_BAD_IDX;
        end else if (req.op == OP_RUN) begin
          if (req.pattern > {1'b0, PAT_FAST}) begin
            res.status = ST_BAD_PAT;
          end else begin
            pat_q[req.led_index]     = req.pattern[1:0];
            timeout_q[req.led_index] = req.life_ms;
            pat_age_q[req.led_index] = '0;
          end
        end else begin
          pat_q[req.led_index]     = PAT_OFF;
          pat_age_q[req.led_index] = '0;
        end
      end
      default: ;
    endcase
    res.led_lit = LedW'(lit_q);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lbpc_out_t want;
    if (!rst_ni) begin
      mask_q = '0;
      slow_q = SLOW_RST;
      fast_q = FAST_RST;
      lit_q  = '0;
      for (int i = 0; i < LedNum; i++) begin
        pat_q[i]       = PAT_OFF;
        level_age_q[i] = '0;
        pat_age_q[i]   = '0;
        timeout_q[i]   = '0;
      end
      awaited_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result: led_lit %b status %0d", out_data_i.led_lit,
                     out_data_i.status);
        end else begin
          want = awaited_q.pop_front();
          if (out_data_i.led_lit !== want.led_lit || out_data_i.status !== want.status) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("result mismatch: led_lit %b/%b status %0d/%0d (expected/actual)",
                       want.led_lit, out_data_i.led_lit, want.status, out_data_i.status);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MASK: mask_q = cfg_wdata_i[LedW-1:0];
          REG_SLOW: slow_q = cfg_wdata_i;
          REG_FAST: fast_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        step_leds(in_data_i, want);
        awaited_q.push_back(want);
      end
    end
    pending_o = awaited_q.size();
  end

endmodule

// ===== test/tb.sv =====
// testbench top: drives requests and register writes into the controller and gives the verdict
module tb;
  import lbpc_pkg::*;

  localparam logic [1:0]         OpUnused  = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int                 LongStall = 60;
  localparam int                 PhaseReqs = 72;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               req_valid;
  logic               req_ready;
  lbpc_in_t           req_data;
  logic               res_valid;
  logic               res_ready;
  lbpc_out_t          res_data;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [HalfW-1:0]   cfg_wdata;
  int                 fail_count;
  int                 pending;
  bit                 idle_en;
  bit                 stall_req;

  always #4 clk = ~clk;

  led_blink_pattern_controller i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_data_i   (req_data),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_data_o  (res_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  led_pattern_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_ready_i   (req_ready),
    .in_data_i    (req_data),
    .out_valid_i  (res_valid),
    .out_ready_i  (res_ready),
    .out_data_i   (res_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic lbpc_in_t mk_req(input logic [1:0] op, input logic [2:0] idx,
                                      input logic [2:0] pat, input logic [31:0] tmo);
    lbpc_in_t r;
    r.op        = op;
    r.led_index = idx;
    r.pattern   = pat;
    r.life_ms   = tmo;
    return r;
  endfunction

  function automatic lbpc_in_t rand_req();
    lbpc_in_t    r;
    int unsigned pick;
    pick        = $urandom_range(0, 99);
    r.led_index = 3'($urandom_range(0, 2));
    r.pattern   = 3'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r.life_ms = '0;
      4, 5, 6, 7: r.life_ms = $urandom_range(1, 300);
      8:          r.life_ms = $urandom;
      default:    r.life_ms = '1;
    endcase
    if (pick < 55) begin
      r.op = OP_TICK;
    end else if (pick < 83) begin
      r.op = OP_RUN;
    end else if (pick < 91) begin
      r.op = OP_RESET;
    end else begin
      case (pick % 3)
        0: begin
          r.op        = OpUnused;
          r.led_index = 3'($urandom);
          r.pattern   = 3'($urandom);
        end
        1: begin
          r.op        = ($urandom_range(0, 1) != 0) ? OP_RUN : OP_RESET;
          r.led_index = 3'($urandom_range(3, 7));
        end
        default: begin
          r.op      = OP_RUN;
          r.pattern = 3'($urandom_range(4, 7));
        end
      endcase
    end
    return r;
  endfunction

  task automatic send_req(input lbpc_in_t req);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= req;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [HalfW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_leds_cfg(input logic [LedW-1:0] mask, input logic [HalfW-1:0] slow,
                              input logic [HalfW-1:0] fast);
    write_reg(REG_MASK, HalfW'(mask));
    write_reg(REG_SLOW, slow);
    write_reg(REG_FAST, fast);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result side: random stalls and one long hold-off
  initial begin
    res_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        res_ready <= 1'b0;
        repeat (LongStall) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    req_valid <= 1'b0;
    req_data  <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    idle_en   = 1'b1;
    stall_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_leds_cfg(3'b111, SLOW_RST, FAST_RST);
    send_req(mk_req(OP_TICK, 3'd0, 3'd0, '0));
    send_req(mk_req(OP_RUN, 3'd0, 3'(PAT_ON), '0));
    send_req(mk_req(OP_RUN, 3'd1, 3'(PAT_SLOW), '0));
    send_req(mk_req(OP_RUN, 3'd2, 3'(PAT_FAST), 32'd30));
    repeat (3) send_req(mk_req(OP_TICK, 3'd0, 3'd0, '0));
    // bad index, bad pattern, unused op
    send_req(mk_req(OP_RUN, 3'd3, 3'(PAT_ON), '0));
    send_req(mk_req(OP_RESET, 3'd7, 3'd7, '1));
    send_req(mk_req(OP_RUN, 3'd0, 3'd4, '0));
    send_req(mk_req(OP_RUN, 3'd1, 3'd7, '1));
    send_req(mk_req(OpUnused, 3'd7, 3'd7, '1));
    // reset ignores the pattern field
    send_req(mk_req(OP_RESET, 3'd0, 3'd7, '0));
    send_req(mk_req(OP_TICK, 3'd7, 3'd7, '1));
    send_req(mk_req(OP_RUN, 3'd1, 3'(PAT_FAST), '1));
    repeat (9) send_req(mk_req(OP_TICK, 3'd0, 3'd0, '0));
    send_req(mk_req(OP_RUN, 3'd2, 3'(PAT_ON), 32'd1));
    send_req(mk_req(OP_TICK, 3'd0, 3'd0, '0));
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_leds_cfg(3'b111, 16'd20, 16'd10);
        1: set_leds_cfg(3'b111, 16'd40, 16'd10);
        2: begin
          write_reg(RegUnused, HalfW'($urandom));
          set_leds_cfg(3'b101, 16'd0, 16'd30);
        end
        3: set_leds_cfg(3'b000, 16'd10, 16'd10);
        4: set_leds_cfg(3'b011, 16'hFFFF, 16'hFFFF);
        5: set_leds_cfg(3'b110, HalfW'($urandom_range(10, 100)), HalfW'($urandom_range(10, 100)));
        default: begin
          set_leds_cfg(3'b111, 16'd50, 16'd0);
          idle_en = 1'b0;
        end
      endcase
      if (p == 1) stall_req = 1'b1;
      for (int n = 0; n < PhaseReqs; n++) begin
        send_req(rand_req());
        if (p == 3 && n == PhaseReqs / 2) wait_idle();
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
